// ===== src/dtfdt_pkg.sv =====
// ----------------------------------------------------------------------------
// dtfdt_pkg
// Shared types, character codes and helper functions for the double to
// fixed decimal text converter.
// ----------------------------------------------------------------------------
package dtfdt_pkg;

  localparam logic [30:0] INT_SAT = 31'h7FFF_FFFF;

  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_DOT   = 7'h2E;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_N     = 7'h6E;
  localparam logic [6:0] CH_A     = 7'h61;
  localparam logic [6:0] CH_I     = 7'h69;
  localparam logic [6:0] CH_F     = 7'h66;

  // sideband carried through the arithmetic stages
  typedef struct packed {
    logic        sgn;
    logic        nan;
    logic        inf;
    logic        ovf;
    logic [30:0] ipart;
    logic [3:0]  prec;
    logic [29:0] scale;
  } side_t;

  // sideband carried through the digit stages
  typedef struct packed {
    logic       sgn;
    logic       nan;
    logic       inf;
    logic       flag;
    logic [3:0] prec;
  } side2_t;

  function automatic logic [29:0] pow10(input logic [3:0] p);
    logic [29:0] r;
    unique case (p)
      4'd0:    r = 30'd1;
      4'd1:    r = 30'd10;
      4'd2:    r = 30'd100;
      4'd3:    r = 30'd1000;
      4'd4:    r = 30'd10000;
      4'd5:    r = 30'd100000;
      4'd6:    r = 30'd1000000;
      4'd7:    r = 30'd10000000;
      4'd8:    r = 30'd100000000;
      4'd9:    r = 30'd1000000000;
      default: r = 30'd1;
    endcase
    return r;
  endfunction

  // eight double-dabble steps: shifts eight binary bits into ten bcd digits
  function automatic logic [39:0] bcd_shift8(input logic [39:0] bcd, input logic [7:0] bits);
    logic [39:0] b;
    b = bcd;
    for (int i = 0; i < 8; i++) begin
      for (int d = 0; d < 10; d++) begin
        if (b[d*4 +: 4] >= 4'd5) begin
          b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
        end
      end
      b = {b[38:0], bits[7-i]};
    end
    return b;
  endfunction

endpackage

// ===== src/double_to_fixed_decimal_text.sv =====
// ----------------------------------------------------------------------------
// double_to_fixed_decimal_text
// Prints a binary64 value as fixed point decimal ascii text, one character
// per output transaction.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  : value_bits_i with in_valid_i / in_stall_o
//   output channel : character_o, last_char_o, range_flag_o with
//                    out_valid_o / out_stall_i
//   config channel : cfg_data_i with cfg_valid_i / cfg_ready_o sets the
//                    number of fraction digits (clamped to the parameter)
// The value runs through a 16 stage pipeline (decode, split multiply, align,
// leading one search, rounding, add one half, rounded floor, integer carry,
// four bcd stages, digit counts, text assembly) and lands in an output
// serialiser. The serialiser emits one character per cycle while the
// receiver does not stall; a number is 3 to 12 + MAX_FRACTION_DIGITS
// characters long. The pipeline keeps accepting while the serialiser is
// busy until it fills. When the receiver stalls the current character
// holds and the pipeline backs up stage by stage with nothing lost. Reset
// empties the pipeline and the serialiser and sets the fraction digit
// count to six.
// ----------------------------------------------------------------------------
module double_to_fixed_decimal_text #(
  parameter int unsigned MAX_FRACTION_DIGITS = 9
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [63:0] value_bits_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic [6:0]  character_o,
  output logic        last_char_o,
  output logic        range_flag_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o
);

  localparam int unsigned NST       = 16;
  localparam int unsigned MAX_CHARS = 12 + MAX_FRACTION_DIGITS;
  localparam int unsigned CW        = $clog2(MAX_CHARS);

  logic [3:0]     frac_digits_q;
  logic [NST-1:0] v_q;
  logic [NST:0]   rdy;

  // ---------------- handshake chain ----------------
  logic          busy_q;
  logic [CW-1:0] cnt_q, len_q;
  logic          ser_last, ser_rdy;

  assign ser_last = (cnt_q == len_q);
  assign ser_rdy  = !busy_q || (!out_stall_i && ser_last);

  always_comb begin
    rdy[NST] = ser_rdy;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o  = !rdy[0];
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_digits_q <= 4'd6;
    end else if (cfg_valid_i) begin
      frac_digits_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // ---------------- stage 1: decode ----------------
  dtfdt_pkg::side_t side_d;
  dtfdt_pkg::side_t side_q [9];
  logic [52:0] mf_d, s1_mf_q;
  logic        left_d;
  logic [6:0]  amt_d;
  logic        left_q [4];
  logic [6:0]  amt_q  [4];

  always_comb begin
    logic [10:0] e, ee, nsa;
    logic [52:0] m, tfull;
    logic [5:0]  sh;
    logic [3:0]  prec;
    e     = value_bits_i[62:52];
    ee    = (e == 11'd0) ? 11'd1 : e;
    m     = {(e != 11'd0), value_bits_i[51:0]};
    sh    = 6'd0;
    tfull = '0;
    nsa   = '0;
    side_d.ipart = '0;
    if (e >= 11'd1075) begin
      mf_d = '0;
    end else if (ee >= 11'd1023) begin
      sh    = 6'(11'd1075 - ee);
      tfull = m >> sh;
      side_d.ipart = tfull[30:0];
      mf_d  = m & ((53'd1 << sh) - 53'd1);
    end else begin
      mf_d = m;
    end
    // alignment of the product onto a grid with 56 fraction bits
    if (ee >= 11'd1019) begin
      left_d = 1'b1;
      amt_d  = 7'(ee - 11'd1019);
    end else begin
      left_d = 1'b0;
      nsa    = 11'd1019 - ee;
      amt_d  = (nsa > 11'd127) ? 7'd127 : nsa[6:0];
    end
    prec = (frac_digits_q > 4'(MAX_FRACTION_DIGITS)) ? 4'(MAX_FRACTION_DIGITS)
                                                      : frac_digits_q;
    side_d.sgn   = value_bits_i[63];
    side_d.inf   = &e;
    side_d.nan   = (&e) && (value_bits_i[51:0] != 52'd0);
    side_d.ovf   = e >= 11'd1054;
    side_d.prec  = prec;
    side_d.scale = dtfdt_pkg::pow10(prec);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      side_q[0] <= side_d;
      s1_mf_q   <= mf_d;
      left_q[0] <= left_d;
      amt_q[0]  <= amt_d;
    end
    for (int k = 1; k < 9; k++) begin
      if (rdy[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
    for (int k = 1; k < 4; k++) begin
      if (rdy[k]) begin
        left_q[k] <= left_q[k-1];
        amt_q[k]  <= amt_q[k-1];
      end
    end
  end

  // ---------------- stages 2..4: split multiply ----------------
  logic [56:0] s2_pl_q, s3_pl_q;
  logic [25:0] s2_mfh_q;
  logic [55:0] s3_ph_q;
  logic [82:0] s4_pm_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s2_pl_q  <= s1_mf_q[26:0] * side_q[0].scale;
      s2_mfh_q <= s1_mf_q[52:27];
    end
    if (rdy[2]) begin
      s3_pl_q <= s2_pl_q;
      s3_ph_q <= s2_mfh_q * side_q[1].scale;
    end
    if (rdy[3]) begin
      s4_pm_q <= 83'({s3_ph_q, 27'd0}) + 83'(s3_pl_q);
    end
  end

  // ---------------- stage 5: align ----------------
  logic [85:0] x_d, s5_x_q, s6_x_q;
  logic        st_d, s5_st_q, s6_st_q;

  always_comb begin
    logic [209:0] tmp;
    tmp = {s4_pm_q, 127'd0} >> amt_q[3];
    if (left_q[3]) begin
      x_d  = 86'(s4_pm_q) << amt_q[3];
      st_d = 1'b0;
    end else begin
      x_d  = 86'(tmp[209:127]);
      st_d = |tmp[126:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      s5_x_q  <= x_d;
      s5_st_q <= st_d;
    end
  end

  // ---------------- stage 6: leading one per 16 bit chunk ----------------
  logic [5:0] nz_d, s6_nz_q;
  logic [3:0] pos_d [6];
  logic [3:0] s6_pos_q [6];

  always_comb begin
    logic [95:0] xp;
    logic [15:0] ch;
    xp = {10'd0, s5_x_q};
    for (int c = 0; c < 6; c++) begin
      ch       = xp[c*16 +: 16];
      nz_d[c]  = |ch;
      pos_d[c] = 4'd0;
      for (int b = 0; b < 16; b++) begin
        if (ch[b]) begin
          pos_d[c] = 4'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      s6_x_q   <= s5_x_q;
      s6_st_q  <= s5_st_q;
      s6_nz_q  <= nz_d;
      s6_pos_q <= pos_d;
    end
  end

  // ---------------- stage 7: round product to 53 bits ----------------
  logic [85:0] p_d, s7_p_q;
  logic [6:0]  l_d, s7_l_q;
  logic        zero_d, s7_zero_q;

  always_comb begin
    logic [6:0]  rpos;
    logic [85:0] lowm, keepm;
    logic        rb, lsb, stk, up;
    l_d = 7'd0;
    for (int c = 0; c < 6; c++) begin
      if (s6_nz_q[c]) begin
        l_d = 7'(c * 16) + {3'd0, s6_pos_q[c]};
      end
    end
    // below a quarter the result always floors to zero
    zero_d = !(|s6_nz_q) || (l_d < 7'd54);
    rpos   = l_d - 7'd53;
    lowm   = (86'd1 << rpos) - 86'd1;
    keepm  = ~((86'd1 << (rpos + 7'd1)) - 86'd1);
    rb     = |(s6_x_q & (86'd1 << rpos));
    lsb    = |(s6_x_q & (86'd1 << (rpos + 7'd1)));
    stk    = (|(s6_x_q & lowm)) || s6_st_q;
    up     = rb && (stk || lsb);
    p_d    = (s6_x_q & keepm) + (up ? (86'd1 << (rpos + 7'd1)) : 86'd0);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      s7_p_q    <= p_d;
      s7_l_q    <= l_d;
      s7_zero_q <= zero_d;
    end
  end

  // ---------------- stage 8: add one half ----------------
  logic [86:0] s8_s_q;
  logic [6:0]  s8_lp_q;
  logic        s8_zero_q;

  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      s8_s_q    <= {1'b0, s7_p_q} + (87'd1 << 55);
      s8_lp_q   <= (|({1'b0, s7_p_q} & (87'd1 << (s7_l_q + 7'd1)))) ? s7_l_q + 7'd1
                                                                    : s7_l_q;
      s8_zero_q <= s7_zero_q;
    end
  end

  // ---------------- stage 9: round sum and take floor ----------------
  logic [30:0] q_d, s9_q_q;

  always_comb begin
    logic [6:0]  ls, rpos;
    logic [86:0] lowm, keepm;
    logic [87:0] r;
    logic        rb, lsb, stk, up;
    if (s8_lp_q < 7'd55) begin
      ls = 7'd55;
    end else begin
      ls = (|(s8_s_q & (87'd1 << (s8_lp_q + 7'd1)))) ? s8_lp_q + 7'd1 : s8_lp_q;
    end
    rpos  = ls - 7'd53;
    lowm  = (87'd1 << rpos) - 87'd1;
    keepm = ~((87'd1 << (rpos + 7'd1)) - 87'd1);
    rb    = |(s8_s_q & (87'd1 << rpos));
    lsb   = |(s8_s_q & (87'd1 << (rpos + 7'd1)));
    stk   = |(s8_s_q & lowm);
    up    = rb && (stk || lsb);
    r     = {1'b0, s8_s_q & keepm} + (up ? (88'd1 << (rpos + 7'd1)) : 88'd0);
    q_d   = s8_zero_q ? 31'd0 : r[86:56];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[8]) begin
      s9_q_q <= q_d;
    end
  end

  // ---------------- stage 10: carry into integer part, saturate ----------------
  dtfdt_pkg::side2_t side2_d;
  dtfdt_pkg::side2_t side2_q [6];
  logic [30:0] ip_d, s10_ip_q;
  logic [29:0] dec_d, s10_dec_q;

  always_comb begin
    logic        carry, sat;
    logic [31:0] ipf;
    carry = s9_q_q >= 31'(side_q[8].scale);
    ipf   = {1'b0, side_q[8].ipart} + 32'(carry);
    sat   = side_q[8].ovf || ipf[31];
    ip_d  = sat ? dtfdt_pkg::INT_SAT : ipf[30:0];
    dec_d = carry ? 30'd0 : s9_q_q[29:0];
    side2_d.sgn  = side_q[8].sgn;
    side2_d.nan  = side_q[8].nan;
    side2_d.inf  = side_q[8].inf;
    side2_d.flag = sat && !side_q[8].inf;
    side2_d.prec = side_q[8].prec;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[9]) begin
      s10_ip_q   <= ip_d;
      s10_dec_q  <= dec_d;
      side2_q[0] <= side2_d;
    end
    for (int k = 1; k < 6; k++) begin
      if (rdy[9+k]) begin
        side2_q[k] <= side2_q[k-1];
      end
    end
  end

  // ---------------- stages 11..14: binary to bcd ----------------
  logic [39:0] dab_bi_q [4];
  logic [39:0] dab_bf_q [4];
  logic [31:0] dab_ri_q [4];
  logic [31:0] dab_rf_q [4];

  always_ff @(posedge clk_i) begin
    if (rdy[10]) begin
      dab_bi_q[0] <= dtfdt_pkg::bcd_shift8(40'd0, {1'b0, s10_ip_q[30:24]});
      dab_bf_q[0] <= dtfdt_pkg::bcd_shift8(40'd0, {2'b0, s10_dec_q[29:24]});
      dab_ri_q[0] <= {s10_ip_q[23:0], 8'd0};
      dab_rf_q[0] <= {s10_dec_q[23:0], 8'd0};
    end
    for (int j = 1; j < 4; j++) begin
      if (rdy[10+j]) begin
        dab_bi_q[j] <= dtfdt_pkg::bcd_shift8(dab_bi_q[j-1], dab_ri_q[j-1][31:24]);
        dab_bf_q[j] <= dtfdt_pkg::bcd_shift8(dab_bf_q[j-1], dab_rf_q[j-1][31:24]);
        dab_ri_q[j] <= {dab_ri_q[j-1][23:0], 8'd0};
        dab_rf_q[j] <= {dab_rf_q[j-1][23:0], 8'd0};
      end
    end
  end

  // ---------------- stage 15: digit counts ----------------
  logic [3:0]  nint_d, s15_nint_q, s15_w_q;
  logic [39:0] s15_bi_q, s15_bf_q;

  always_comb begin
    nint_d = 4'd1;
    for (int i = 0; i < 10; i++) begin
      if (dab_bi_q[3][i*4 +: 4] != 4'd0) begin
        nint_d = 4'(i + 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[14]) begin
      s15_nint_q <= nint_d;
      s15_w_q    <= (side2_q[4].prec == 4'd0) ? 4'd1 : side2_q[4].prec;
      s15_bi_q   <= dab_bi_q[3];
      s15_bf_q   <= dab_bf_q[3];
    end
  end

  // ---------------- stage 16: text assembly ----------------
  logic [6:0]    txt_d [MAX_CHARS];
  logic [6:0]    txt_q [MAX_CHARS];
  logic [CW-1:0] tlen_d, tlen_q;
  logic          tflag_q;

  always_comb begin
    logic [4:0] off, dotp, kk, lenm1;
    logic [3:0] di, fi;
    dtfdt_pkg::side2_t sd;
    sd    = side2_q[5];
    off   = {4'd0, sd.sgn};
    dotp  = off + {1'b0, s15_nint_q};
    lenm1 = dotp + {1'b0, s15_w_q};
    di    = 4'd0;
    fi    = 4'd0;
    for (int k = 0; k < MAX_CHARS; k++) begin
      kk = 5'(k);
      txt_d[k] = dtfdt_pkg::CH_ZERO;
      if (sd.nan) begin
        if (k == 1) begin
          txt_d[k] = dtfdt_pkg::CH_A;
        end else begin
          txt_d[k] = dtfdt_pkg::CH_N;
        end
      end else if (sd.inf) begin
        if (kk < off) begin
          txt_d[k] = dtfdt_pkg::CH_MINUS;
        end else if (kk == off) begin
          txt_d[k] = dtfdt_pkg::CH_I;
        end else if (kk == off + 5'd1) begin
          txt_d[k] = dtfdt_pkg::CH_N;
        end else begin
          txt_d[k] = dtfdt_pkg::CH_F;
        end
      end else if (kk < off) begin
        txt_d[k] = dtfdt_pkg::CH_MINUS;
      end else if (kk < dotp) begin
        di = 4'(dotp - 5'd1 - kk);
        if (di <= 4'd9) begin
          txt_d[k] = dtfdt_pkg::CH_ZERO | {3'd0, s15_bi_q[di*4 +: 4]};
        end
      end else if (kk == dotp) begin
        txt_d[k] = dtfdt_pkg::CH_DOT;
      end else begin
        fi = 4'(dotp + {1'b0, s15_w_q} - kk);
        if (fi <= 4'd9) begin
          txt_d[k] = dtfdt_pkg::CH_ZERO | {3'd0, s15_bf_q[fi*4 +: 4]};
        end
      end
    end
    if (sd.nan) begin
      tlen_d = CW'(2);
    end else if (sd.inf) begin
      tlen_d = sd.sgn ? CW'(3) : CW'(2);
    end else begin
      tlen_d = CW'(lenm1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[15]) begin
      txt_q   <= txt_d;
      tlen_q  <= tlen_d;
      tflag_q <= side2_q[5].flag;
    end
  end

  // ---------------- output serialiser ----------------
  logic [6:0] buf_q [MAX_CHARS];
  logic       flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ser_rdy) begin
      busy_q <= v_q[NST-1];
      cnt_q  <= '0;
    end else if (!out_stall_i) begin
      cnt_q <= cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_rdy && v_q[NST-1]) begin
      buf_q  <= txt_q;
      len_q  <= tlen_q;
      flag_q <= tflag_q;
    end
  end

  assign out_valid_o  = busy_q;
  assign character_o  = buf_q[cnt_q];
  assign last_char_o  = ser_last;
  assign range_flag_o = flag_q;

`ifndef SYNTHESIS
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[0])
    else $error("accepted transaction did not enter the pipeline");

  a_cnt_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q <= len_q))
    else $error("character index beyond text length");

  a_drain_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_char_o && !out_stall_i && !v_q[NST-1]) |=> !out_valid_o)
    else $error("serialiser did not go idle after last character");

  a_flag_numeric : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_flag_o) |->
      (character_o != dtfdt_pkg::CH_N && character_o != dtfdt_pkg::CH_I))
    else $error("range flag set on special value text");
`endif

endmodule
